// ===== rtl/core/byte_ring_fifo_with_peek_defines.svh =====
// Assertion macros for the byte ring FIFO.
// Used by byte_ring_fifo_with_peek; expects clk_i and rst_ni in scope.
`ifndef BYTE_RING_FIFO_WITH_PEEK_DEFINES_SVH
`define BYTE_RING_FIFO_WITH_PEEK_DEFINES_SVH

// Same-cycle implication, gated by reset.
`define BRF_ASSERT_IMPLIES(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, gated by reset.
`define BRF_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/brf_pkg.sv =====
// Shared types and constants for the byte ring FIFO.
// No dependencies.
`default_nettype none

package brf_pkg;

  localparam int unsigned RING_DEPTH_DEF = 256;
  localparam int unsigned MAX_BURST_DEF  = 64;

  localparam int unsigned SIZE_W     = 9;
  localparam logic [SIZE_W-1:0] SIZE_RESET = 9'd256;
  localparam int unsigned PADDR_W    = 3;
  localparam logic        REG_SIZE_IN_USE = 1'b0;  // paddr[2] of the size register

  // Input modes
  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_READ  = 2'd1;
  localparam logic [1:0] MODE_PEEK  = 2'd2;

  // Result status codes
  localparam logic [1:0] STAT_OK       = 2'd0;
  localparam logic [1:0] STAT_NO_SPACE = 2'd1;
  localparam logic [1:0] STAT_INVALID  = 2'd2;

  typedef enum logic {
    ST_IDLE,
    ST_FETCH
  } state_e;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] read_byte;
    logic       byte_valid;
    logic [6:0] byte_count;
    logic       is_last;
    logic [7:0] used_bytes;
    logic [7:0] free_bytes;
  } res_t;

endpackage

`default_nettype wire

// ===== rtl/core/brf_ring_mem.sv =====
// Byte storage of the ring: one write port, one registered read port.
// Uses brf_pkg only for the default depth; no other dependencies.
`default_nettype none

module brf_ring_mem import brf_pkg::*; #(
  parameter int unsigned DEPTH = RING_DEPTH_DEF,
  parameter int unsigned AW    = 8
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [7:0]    wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output logic      [7:0]    rdata_o
);

  logic [7:0] mem_q [DEPTH];
  logic [7:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read enable.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ===== rtl/core/brf_ctrl.sv =====
// Pointer, burst and fetch sequencing for the byte ring FIFO, with output register.
// Depends on brf_pkg; drives brf_ring_mem ports.
`default_nettype none

module brf_ctrl import brf_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF,
  parameter int unsigned MAX_BURST  = MAX_BURST_DEF,
  parameter int unsigned AW         = 8
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_clear_i,
  input  wire logic [SIZE_W-1:0] size_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [1:0]        mode_i,
  input  wire logic [7:0]        write_byte_i,
  input  wire logic              first_of_burst_i,
  input  wire logic [6:0]        burst_length_i,
  input  wire logic [7:0]        peek_offset_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output res_t                   res_o,
  output logic                   mem_we_o,
  output logic      [AW-1:0]     mem_waddr_o,
  output logic      [7:0]        mem_wdata_o,
  output logic                   mem_re_o,
  output logic      [AW-1:0]     mem_raddr_o,
  input  wire logic [7:0]        mem_rdata_i
);

  localparam int unsigned LW = $clog2(RING_DEPTH + 1);
  localparam int unsigned CW = (LW > 8) ? LW : 8;
  localparam int unsigned SW = CW + 1;

  state_e        state_q, state_d;
  logic [AW-1:0] wr_q, wr_d, rd_q, rd_d, addr_q, addr_d;
  logic          acc_q, acc_d;
  logic [6:0]    rem_q, rem_d;
  logic [6:0]    beats_q, beats_d, total_q, total_d;
  logic [7:0]    used_q, used_d, free_q, free_d;
  logic          out_valid_q, out_valid_d;
  res_t          res_q, res_d;

  logic [LW-1:0] ring_len, used_c, free_c, avail_c;
  logic [LW-1:0] wr_p1, addr_p1, start_p1;
  logic [SW-1:0] start_sum, rd_sum;
  logic [AW-1:0] wr_inc, addr_inc, start_c, start_inc, rd_after;
  logic [6:0]    len_c, fetch_n;
  logic          out_free, accept, is_fetch, fetch_go, last_beat, peek_empty;
  logic          w_store, acc_n;
  logic [6:0]    rem_n;
  logic [1:0]    w_stat;

  // Effective ring length, clamped to 2..RING_DEPTH
  always_comb begin
    if (size_i < SIZE_W'(2)) begin
      ring_len = LW'(2);
    end else if (32'(size_i) > 32'(RING_DEPTH)) begin
      ring_len = LW'(RING_DEPTH);
    end else begin
      ring_len = LW'(size_i);
    end
  end

  assign used_c = (wr_q >= rd_q) ? (LW'(wr_q) - LW'(rd_q))
                                 : (LW'(wr_q) + ring_len - LW'(rd_q));
  assign free_c = ring_len - LW'(1) - used_c;

  assign len_c = (burst_length_i > 7'(MAX_BURST)) ? 7'(MAX_BURST) : burst_length_i;

  // Wrapping increments
  assign wr_p1    = LW'(wr_q) + LW'(1);
  assign wr_inc   = (wr_p1 == ring_len) ? '0 : AW'(wr_p1);
  assign addr_p1  = LW'(addr_q) + LW'(1);
  assign addr_inc = (addr_p1 == ring_len) ? '0 : AW'(addr_p1);

  // Fetch plan: start address, byte count, read pointer after a read
  assign peek_empty = (mode_i == MODE_PEEK) && (CW'(peek_offset_i) >= CW'(used_c));
  assign avail_c    = (mode_i == MODE_PEEK) ? (used_c - LW'(peek_offset_i)) : used_c;
  assign start_sum  = (mode_i == MODE_PEEK) ? (SW'(rd_q) + SW'(peek_offset_i)) : SW'(rd_q);
  assign start_c    = (start_sum >= SW'(ring_len)) ? AW'(start_sum - SW'(ring_len))
                                                   : AW'(start_sum);
  assign start_p1   = LW'(start_c) + LW'(1);
  assign start_inc  = (start_p1 == ring_len) ? '0 : AW'(start_p1);

  always_comb begin
    if (len_c == '0 || peek_empty) begin
      fetch_n = '0;
    end else if (CW'(avail_c) < CW'(len_c)) begin
      fetch_n = 7'(avail_c);
    end else begin
      fetch_n = len_c;
    end
  end

  assign rd_sum   = SW'(start_c) + SW'(fetch_n);
  assign rd_after = (rd_sum >= SW'(ring_len)) ? AW'(rd_sum - SW'(ring_len)) : AW'(rd_sum);

  // Write burst bookkeeping
  always_comb begin
    w_store = 1'b0;
    acc_n   = acc_q;
    rem_n   = rem_q;
    w_stat  = STAT_OK;
    if (first_of_burst_i) begin
      if (len_c == '0) begin
        acc_n  = 1'b0;
        rem_n  = '0;
        w_stat = STAT_INVALID;
      end else if (CW'(free_c) < CW'(len_c)) begin
        acc_n  = 1'b0;
        rem_n  = len_c - 7'd1;
        w_stat = STAT_NO_SPACE;
      end else begin
        w_store = 1'b1;
        rem_n   = len_c - 7'd1;
        acc_n   = (len_c != 7'd1);
      end
    end else if (rem_q != '0) begin
      rem_n   = rem_q - 7'd1;
      w_store = acc_q;
      w_stat  = acc_q ? STAT_OK : STAT_NO_SPACE;
      if (rem_q == 7'd1) begin
        acc_n = 1'b0;
      end
    end else begin
      w_stat = STAT_INVALID;
    end
  end

  assign out_free  = !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) && out_free;
  assign accept    = in_valid_i && in_ready_o;
  assign is_fetch  = (mode_i == MODE_READ) || (mode_i == MODE_PEEK);
  assign fetch_go  = accept && is_fetch && (fetch_n != '0);
  assign last_beat = (state_q == ST_FETCH) && out_free && (beats_q == 7'd1);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (fetch_go) state_d = ST_FETCH;
      ST_FETCH: if (last_beat) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory control
  always_comb begin
    wr_d        = wr_q;
    rd_d        = rd_q;
    addr_d      = addr_q;
    acc_d       = acc_q;
    rem_d       = rem_q;
    beats_d     = beats_q;
    total_d     = total_q;
    used_d      = used_q;
    free_d      = free_q;
    res_d       = res_q;
    out_valid_d = out_valid_q && !out_ready_i;
    mem_we_o    = 1'b0;
    mem_waddr_o = wr_q;
    mem_wdata_o = write_byte_i;
    mem_re_o    = 1'b0;
    mem_raddr_o = addr_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          res_d.read_byte  = '0;
          res_d.byte_valid = 1'b0;
          res_d.byte_count = '0;
          res_d.is_last    = 1'b1;
          res_d.used_bytes = 8'(used_c);
          res_d.free_bytes = 8'(free_c);
          unique case (mode_i)
            MODE_WRITE: begin
              out_valid_d  = 1'b1;
              res_d.status = w_stat;
              acc_d        = acc_n;
              rem_d        = rem_n;
              if (w_store) begin
                mem_we_o         = 1'b1;
                wr_d             = wr_inc;
                res_d.used_bytes = 8'(used_c + LW'(1));
                res_d.free_bytes = 8'(free_c - LW'(1));
              end
            end
            MODE_READ, MODE_PEEK: begin
              if (fetch_go) begin
                mem_re_o    = 1'b1;
                mem_raddr_o = start_c;
                addr_d      = start_inc;
                beats_d     = fetch_n;
                total_d     = fetch_n;
                if (mode_i == MODE_READ) begin
                  rd_d   = rd_after;
                  used_d = 8'(used_c - LW'(fetch_n));
                  free_d = 8'(free_c + LW'(fetch_n));
                end else begin
                  used_d = 8'(used_c);
                  free_d = 8'(free_c);
                end
              end else begin
                out_valid_d  = 1'b1;
                res_d.status = (len_c == '0) ? STAT_INVALID : STAT_OK;
              end
            end
            default: begin
              out_valid_d  = 1'b1;
              res_d.status = STAT_INVALID;
            end
          endcase
        end
      end
      ST_FETCH: begin
        // Read data for the current byte is valid; next read issues as it drains.
        if (out_free) begin
          out_valid_d      = 1'b1;
          res_d.status     = STAT_OK;
          res_d.read_byte  = mem_rdata_i;
          res_d.byte_valid = 1'b1;
          res_d.is_last    = (beats_q == 7'd1);
          res_d.byte_count = (beats_q == 7'd1) ? total_q : '0;
          res_d.used_bytes = used_q;
          res_d.free_bytes = free_q;
          beats_d          = beats_q - 7'd1;
          if (beats_q != 7'd1) begin
            mem_re_o = 1'b1;
            addr_d   = addr_inc;
          end
        end
      end
      default: ;
    endcase

    if (cfg_clear_i) begin
      wr_d  = '0;
      rd_d  = '0;
      acc_d = 1'b0;
      rem_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      wr_q        <= '0;
      rd_q        <= '0;
      acc_q       <= 1'b0;
      rem_q       <= '0;
      beats_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      wr_q        <= wr_d;
      rd_q        <= rd_d;
      acc_q       <= acc_d;
      rem_q       <= rem_d;
      beats_q     <= beats_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q  <= addr_d;
    total_q <= total_d;
    used_q  <= used_d;
    free_q  <= free_d;
    res_q   <= res_d;
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/byte_ring_fifo_with_peek.sv =====
// Top level of the byte ring FIFO with peek: APB size register, control, storage.
// Depends on brf_pkg, brf_ctrl, brf_ring_mem and byte_ring_fifo_with_peek_defines.svh.
`default_nettype none

`include "byte_ring_fifo_with_peek_defines.svh"

// Byte ring FIFO whose active length comes from the size_in_use register
// (clamped to 2..RING_DEPTH, one slot always kept empty). Write transactions
// carry one byte each; the first byte of a burst carries its length and the
// burst is stored only if it fits whole. Read and peek transactions return
// one result per byte, the last one carrying the byte count. A write, a
// zero-length or empty request, or an unknown mode produces one result. A
// read or peek first accepts the request and issues the first memory read,
// then produces one result per byte, paced by the single registered read
// port of the storage. The next transaction is accepted once the fetch is
// done and the output register can take a result; backpressure on the
// output stalls the fetch in place. The storage is not cleared after reset:
// bytes never written read back as unknown. Writing size_in_use empties the
// ring and drops any open burst; write it only while no transaction is in
// flight.

module byte_ring_fifo_with_peek import brf_pkg::*; #(
  parameter int unsigned RING_DEPTH = RING_DEPTH_DEF,
  parameter int unsigned MAX_BURST  = MAX_BURST_DEF
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // APB configuration port
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output logic      [31:0]        prdata,
  output logic                    pready,
  // Input transactions
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [1:0]         mode_i,
  input  wire logic [7:0]         write_byte_i,
  input  wire logic               first_of_burst_i,
  input  wire logic [6:0]         burst_length_i,
  input  wire logic [7:0]         peek_offset_i,
  // Result transactions
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic      [1:0]         status_o,
  output logic      [7:0]         read_byte_o,
  output logic                    byte_valid_o,
  output logic      [6:0]         byte_count_o,
  output logic                    is_last_o,
  output logic      [7:0]         used_bytes_o,
  output logic      [7:0]         free_bytes_o
);

  localparam int unsigned AW = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;

  logic [SIZE_W-1:0] size_q, size_d;
  logic              cfg_wr;
  res_t              res;
  logic              mem_we, mem_re;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [7:0]        mem_wdata, mem_rdata;

  // APB: zero wait states; only the size register is decoded
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_SIZE_IN_USE);
  assign size_d = cfg_wr ? pwdata[SIZE_W-1:0] : size_q;
  assign prdata = (paddr[2] == REG_SIZE_IN_USE) ? 32'(size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else begin
      size_q <= size_d;
    end
  end

  brf_ctrl #(
    .RING_DEPTH (RING_DEPTH),
    .MAX_BURST  (MAX_BURST),
    .AW         (AW)
  ) u_ctrl (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_clear_i      (cfg_wr),
    .size_i           (size_q),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .write_byte_i     (write_byte_i),
    .first_of_burst_i (first_of_burst_i),
    .burst_length_i   (burst_length_i),
    .peek_offset_i    (peek_offset_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .res_o            (res),
    .mem_we_o         (mem_we),
    .mem_waddr_o      (mem_waddr),
    .mem_wdata_o      (mem_wdata),
    .mem_re_o         (mem_re),
    .mem_raddr_o      (mem_raddr),
    .mem_rdata_i      (mem_rdata)
  );

  brf_ring_mem #(
    .DEPTH (RING_DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

  assign status_o     = res.status;
  assign read_byte_o  = res.read_byte;
  assign byte_valid_o = res.byte_valid;
  assign byte_count_o = res.byte_count;
  assign is_last_o    = res.is_last;
  assign used_bytes_o = res.used_bytes;
  assign free_bytes_o = res.free_bytes;

  // A transaction is taken only when the output register has room for its first result.
  `BRF_ASSERT_IMPLIES(a_accept_needs_room, in_valid_i && in_ready_o, !out_valid_o || out_ready_i, "accepted with output register full")
  // A write answers with a single byteless result in the next cycle.
  `BRF_ASSERT_NEXT(a_write_single_result, in_valid_i && in_ready_o && mode_i == MODE_WRITE, out_valid_o && is_last_o && !byte_valid_o, "write result missing or malformed")
  // Only the last result of a fetch may carry a count; earlier ones carry bytes.
  `BRF_ASSERT_IMPLIES(a_count_only_on_last, out_valid_o && !is_last_o, byte_valid_o && byte_count_o == 7'd0, "non-last result malformed")
  // A result without a byte always closes its transaction.
  `BRF_ASSERT_IMPLIES(a_byteless_is_last, out_valid_o && !byte_valid_o, is_last_o && byte_count_o == 7'd0, "byteless result not last")

endmodule

`default_nettype wire

// ===== sim/byte_ring_fifo_with_peek_tb.sv =====
// Self-checking testbench for byte_ring_fifo_with_peek: directed corner cases, then random
// phases at several ring sizes. Depends on brf_pkg and the RTL under rtl/core only.
`default_nettype none

module byte_ring_fifo_with_peek_tb;
  import brf_pkg::*;

  // The fourth mode code has no meaning; the block answers it as invalid.
  localparam logic [1:0] MODE_RSVD = 2'd3;
  localparam logic [PADDR_W-1:0] SIZE_ADDR = {REG_SIZE_IN_USE, 2'b00};
  localparam int unsigned REPORT_LIMIT = 10;

  // --------------------------------------------------------------------------
  // Scoreboard: shadow copy of the ring plus the queue of results still owed.
  // Each accepted input transaction is predicted at its acceptance edge.
  // --------------------------------------------------------------------------
  class ring_scoreboard;
    logic [7:0]  ring_mem [RING_DEPTH_DEF];
    int unsigned wr_ptr;
    int unsigned rd_ptr;
    int unsigned burst_left;
    bit          burst_ok;
    logic [8:0]  size_reg;
    res_t        owed_q[$];
    int unsigned errors;

    function new();
      size_reg   = SIZE_RESET;
      wr_ptr     = 0;
      rd_ptr     = 0;
      burst_left = 0;
      burst_ok   = 1'b0;
      errors     = 0;
    endfunction

    // Active ring length: register value clamped to 2..depth.
    function int unsigned ring_len();
      int unsigned s;
      s = size_reg;
      if (s < 2) s = 2;
      if (s > RING_DEPTH_DEF) s = RING_DEPTH_DEF;
      return s;
    endfunction

    function int unsigned used_count();
      return (wr_ptr + ring_len() - rd_ptr) % ring_len();
    endfunction

    function int unsigned free_count();
      return ring_len() - 1 - used_count();
    endfunction

    function int unsigned pending();
      return owed_q.size();
    endfunction

    // Size write empties the ring and drops any open burst.
    function void set_size(logic [8:0] value);
      size_reg   = value;
      wr_ptr     = 0;
      rd_ptr     = 0;
      burst_left = 0;
      burst_ok   = 1'b0;
    endfunction

    function void store_byte(logic [7:0] b);
      ring_mem[wr_ptr] = b;
      wr_ptr = (wr_ptr + 1) % ring_len();
    endfunction

    // Fill level is taken after the whole transaction has updated the state.
    function void push_result(logic [1:0] st, logic [7:0] data, logic valid,
                              logic [6:0] cnt, logic last);
      res_t r;
      r.status     = st;
      r.read_byte  = data;
      r.byte_valid = valid;
      r.byte_count = cnt;
      r.is_last    = last;
      r.used_bytes = 8'(used_count());
      r.free_bytes = 8'(free_count());
      owed_q.push_back(r);
    endfunction

    function void note_input(logic [1:0] mode, logic [7:0] wbyte, logic sof,
                             logic [6:0] blen, logic [7:0] poff);
      int unsigned len;
      int unsigned s;
      int unsigned n;
      int unsigned start;
      logic [7:0]  grab [MAX_BURST_DEF];
      logic [1:0]  st;
      len = blen;
      if (len > MAX_BURST_DEF) len = MAX_BURST_DEF;
      s = ring_len();
      case (mode)
        MODE_WRITE: begin
          if (sof) begin
            if (len == 0) begin
              burst_ok   = 1'b0;
              burst_left = 0;
              st         = STAT_INVALID;
            end else if (free_count() < len) begin
              // whole burst refused; its later bytes still report no space
              burst_ok   = 1'b0;
              burst_left = len - 1;
              st         = STAT_NO_SPACE;
            end else begin
              store_byte(wbyte);
              burst_left = len - 1;
              burst_ok   = (burst_left > 0);
              st         = STAT_OK;
            end
          end else if (burst_left > 0) begin
            burst_left--;
            if (burst_ok) begin
              store_byte(wbyte);
              st = STAT_OK;
            end else begin
              st = STAT_NO_SPACE;
            end
            if (burst_left == 0) burst_ok = 1'b0;
          end else begin
            st = STAT_INVALID;  // stray byte, no burst open
          end
          push_result(st, 8'd0, 1'b0, 7'd0, 1'b1);
        end
        MODE_READ, MODE_PEEK: begin
          if (len == 0) begin
            push_result(STAT_INVALID, 8'd0, 1'b0, 7'd0, 1'b1);
          end else begin
            n     = used_count();
            start = rd_ptr;
            if (mode == MODE_PEEK) begin
              if (poff >= n) begin
                n = 0;
              end else begin
                n     = n - poff;
                start = (start + poff) % s;
              end
            end
            if (n > len) n = len;
            if (n == 0) begin
              push_result(STAT_OK, 8'd0, 1'b0, 7'd0, 1'b1);
            end else begin
              for (int i = 0; i < n; i++) grab[i] = ring_mem[(start + i) % s];
              if (mode == MODE_READ) rd_ptr = (start + n) % s;
              for (int i = 0; i < n; i++)
                push_result(STAT_OK, grab[i], 1'b1, (i + 1 == n) ? 7'(n) : 7'd0, i + 1 == n);
            end
          end
        end
        default: push_result(STAT_INVALID, 8'd0, 1'b0, 7'd0, 1'b1);
      endcase
    endfunction

    function string fmt_result(res_t r);
      return $sformatf("st=%0d byte=%02h v=%0b cnt=%0d last=%0b used=%0d free=%0d",
                       r.status, r.read_byte, r.byte_valid, r.byte_count, r.is_last,
                       r.used_bytes, r.free_bytes);
    endfunction

    function void check_result(res_t got);
      res_t want;
      if (owed_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_LIMIT) $display("unexpected result: %s", fmt_result(got));
        return;
      end
      want = owed_q.pop_front();
      if (got !== want) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("result mismatch\n  exp %s\n  got %s", fmt_result(want), fmt_result(got));
      end
    endfunction

    function void check_size(logic [8:0] want, logic [31:0] got);
      if (got !== {23'd0, want}) begin
        errors++;
        if (errors <= REPORT_LIMIT)
          $display("size readback mismatch: exp %0d got %0d", want, got);
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset and block inputs (all known from time zero)
  // --------------------------------------------------------------------------
  logic        clk_i            = 1'b0;
  logic        rst_ni           = 1'b0;
  logic        psel             = 1'b0;
  logic        penable          = 1'b0;
  logic        pwrite           = 1'b0;
  logic [PADDR_W-1:0] paddr     = '0;
  logic [31:0] pwdata           = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i       = 1'b0;
  logic        in_ready_o;
  logic [1:0]  mode_i           = MODE_WRITE;
  logic [7:0]  write_byte_i     = '0;
  logic        first_of_burst_i = 1'b0;
  logic [6:0]  burst_length_i   = '0;
  logic [7:0]  peek_offset_i    = '0;
  logic        out_valid_o;
  logic        out_ready_i      = 1'b0;
  logic [1:0]  status_o;
  logic [7:0]  read_byte_o;
  logic        byte_valid_o;
  logic [6:0]  byte_count_o;
  logic        is_last_o;
  logic [7:0]  used_bytes_o;
  logic [7:0]  free_bytes_o;

  logic [7:0]  ready_phase = 8'd0;
  int          sender_run  = 0;   // transactions left in the current sender burst
  ring_scoreboard sb;

  // Sizes for the random phases; the zero slot is replaced by a random size.
  logic [8:0] phase_size [8] = '{9'd511, 9'd1, 9'd3, 9'd17, 9'd256, 9'd100, 9'd0, 9'd64};

  byte_ring_fifo_with_peek DUT (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .mode_i           (mode_i),
    .write_byte_i     (write_byte_i),
    .first_of_burst_i (first_of_burst_i),
    .burst_length_i   (burst_length_i),
    .peek_offset_i    (peek_offset_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .status_o         (status_o),
    .read_byte_o      (read_byte_o),
    .byte_valid_o     (byte_valid_o),
    .byte_count_o     (byte_count_o),
    .is_last_o        (is_last_o),
    .used_bytes_o     (used_bytes_o),
    .free_bytes_o     (free_bytes_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // Receiver backpressure: a repeating pattern, stepped by ready_phase, cycling through
  // always ready, coin-flip ready, isolated ready pulses, and stalls.
  always @(negedge clk_i) begin
    ready_phase <= ready_phase + 8'd1;
    case (ready_phase[7:6])
      2'd0:    out_ready_i <= 1'b1;
      2'd1:    out_ready_i <= 1'($urandom_range(0, 1));
      2'd2:    out_ready_i <= (ready_phase[1:0] == 2'd0);
      default: out_ready_i <= (ready_phase[3:0] >= 4'd10);
    endcase
  end

  // Monitor: note the input transaction before checking the output one, so a
  // result can never overtake its own prediction within a time step.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o)
        sb.note_input(mode_i, write_byte_i, first_of_burst_i, burst_length_i, peek_offset_i);
      if (out_valid_o && out_ready_i)
        sb.check_result({status_o, read_byte_o, byte_valid_o, byte_count_o, is_last_o,
                         used_bytes_o, free_bytes_o});
    end
  end

  // --------------------------------------------------------------------------
  // Drivers. All tasks start and end just after a falling edge.
  // --------------------------------------------------------------------------

  // One input transaction; the sender idles between bursts of random length.
  task automatic send_item(input logic [1:0] mode, input logic [7:0] wbyte, input logic sof,
                           input logic [6:0] blen, input logic [7:0] poff);
    int gap;
    if (sender_run == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      repeat (gap) @(negedge clk_i);
      sender_run = $urandom_range(1, 24);
    end
    sender_run--;
    in_valid_i       = 1'b1;
    mode_i           = mode;
    write_byte_i     = wbyte;
    first_of_burst_i = sof;
    burst_length_i   = blen;
    peek_offset_i    = poff;
    do @(posedge clk_i); while (!in_ready_o);
    @(negedge clk_i);
    in_valid_i = 1'b0;
  endtask

  task automatic apb_check_size(input logic [8:0] value);
    logic [31:0] got;
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = SIZE_ADDR;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    got = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    sb.check_size(value, got);
  endtask

  // Setup cycle, access cycle, then read the register back.
  task automatic apb_write_size(input logic [8:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = SIZE_ADDR;
    pwdata  = {23'd0, value};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_size(value);
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    apb_check_size(value);
  endtask

  // Block is idle once every owed result has come out (each transaction
  // yields at least one result).
  task automatic wait_drained();
    while (sb.pending() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  function automatic logic [7:0] rnd_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  // Read/peek length: mostly in range, sometimes above the clamp.
  function automatic logic [6:0] pick_req_len();
    if ($urandom_range(0, 9) == 0) return 7'($urandom_range(65, 127));
    return 7'($urandom_range(1, 64));
  endfunction

  // Random phase: mostly well-formed bursts, reads and peeks; the rest is
  // truncated bursts and malformed transactions.
  task automatic run_phase(input int quota);
    int sent;
    int pick;
    int len;
    int cap;
    int cut;
    int used;
    logic [6:0] blen;
    logic [7:0] off;
    sent = 0;
    while (sent < quota) begin
      pick = $urandom_range(0, 99);
      used = sb.used_count();
      if (pick < 45) begin
        // complete write burst, usually sized to fit the free space
        cap = sb.free_count();
        if (cap > 64) cap = 64;
        if (cap == 0 || $urandom_range(0, 5) == 0) len = $urandom_range(1, 64);
        else if ($urandom_range(0, 3) == 0) len = $urandom_range(1, cap);
        else len = $urandom_range(1, (cap < 8) ? cap : 8);
        // keep the phase at its quota
        if (len > quota - sent) len = quota - sent;
        blen = 7'(len);
        if (len == 64 && $urandom_range(0, 1) == 1) blen = 7'($urandom_range(65, 127));
        for (int i = 0; i < len; i++)
          send_item(MODE_WRITE, rnd_byte(), i == 0, (i == 0) ? blen : 7'($urandom_range(0, 127)),
                    rnd_byte());
        sent += len;
      end else if (pick < 52) begin
        // burst cut short; the next first byte closes it
        len = $urandom_range(2, 16);
        cut = $urandom_range(1, len - 1);
        if (cut > quota - sent) cut = quota - sent;
        for (int i = 0; i < cut; i++)
          send_item(MODE_WRITE, rnd_byte(), i == 0, (i == 0) ? 7'(len) : 7'($urandom_range(0, 127)),
                    rnd_byte());
        sent += cut;
      end else if (pick < 72) begin
        send_item(MODE_READ, rnd_byte(), 1'($urandom_range(0, 1)), pick_req_len(), rnd_byte());
        sent++;
      end else if (pick < 90) begin
        if (used > 0 && $urandom_range(0, 3) != 0) off = 8'($urandom_range(0, used - 1));
        else off = rnd_byte();
        send_item(MODE_PEEK, rnd_byte(), 1'($urandom_range(0, 1)), pick_req_len(), off);
        sent++;
      end else begin
        case ($urandom_range(0, 3))
          0: send_item(MODE_WRITE, rnd_byte(), 1'b0, 7'($urandom_range(0, 127)), rnd_byte());
          1: send_item(MODE_WRITE, rnd_byte(), 1'b1, 7'd0, rnd_byte());
          2: send_item(($urandom_range(0, 1) == 1) ? MODE_READ : MODE_PEEK, rnd_byte(),
                       1'($urandom_range(0, 1)), 7'd0, rnd_byte());
          default: send_item(MODE_RSVD, rnd_byte(), 1'($urandom_range(0, 1)),
                             7'($urandom_range(0, 127)), rnd_byte());
        endcase
        sent++;
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    sb = new();
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    apb_check_size(SIZE_RESET);

    // Directed, full-size ring: malformed requests on an empty ring first.
    send_item(MODE_WRITE, 8'h5A, 1'b0, 7'd9, 8'h00);    // stray byte
    send_item(MODE_WRITE, 8'h00, 1'b1, 7'd0, 8'h00);    // zero-length burst
    send_item(MODE_READ,  8'h00, 1'b0, 7'd0, 8'h00);    // zero-length read
    send_item(MODE_READ,  8'h00, 1'b0, 7'd5, 8'h00);    // read of empty ring
    send_item(MODE_PEEK,  8'h00, 1'b0, 7'd5, 8'h00);    // peek of empty ring
    send_item(MODE_RSVD,  8'hFF, 1'b1, 7'h7F, 8'hFF);   // unused mode
    // Burst of four interrupted after two bytes by a new burst of two.
    send_item(MODE_WRITE, 8'h00, 1'b1, 7'd4, 8'h00);
    send_item(MODE_WRITE, 8'hFF, 1'b0, 7'h7F, 8'hFF);
    send_item(MODE_WRITE, 8'h3C, 1'b1, 7'd2, 8'h00);
    send_item(MODE_WRITE, 8'hC3, 1'b0, 7'd0, 8'h00);
    send_item(MODE_PEEK,  8'h00, 1'b0, 7'd2, 8'd1);     // middle bytes
    send_item(MODE_PEEK,  8'h00, 1'b0, 7'h7F, 8'hFF);   // offset past stored data
    send_item(MODE_PEEK,  8'h00, 1'b0, 7'd0, 8'd3);     // zero-length peek
    send_item(MODE_READ,  8'h00, 1'b0, 7'h7F, 8'h00);   // over-long read drains all
    // Over-long burst length is clamped; leave it open across a read.
    send_item(MODE_WRITE, 8'hE7, 1'b1, 7'h7F, 8'h00);
    send_item(MODE_READ,  8'h00, 1'b0, 7'd64, 8'h00);

    // Smallest ring (size clamps up to two): capacity of one byte.
    wait_drained();
    apb_write_size(9'd0);
    send_item(MODE_WRITE, 8'h11, 1'b1, 7'd2, 8'h00);    // does not fit
    send_item(MODE_WRITE, 8'h22, 1'b0, 7'd0, 8'h00);    // dropped tail byte
    send_item(MODE_WRITE, 8'h81, 1'b1, 7'd1, 8'h00);    // fills the ring
    send_item(MODE_WRITE, 8'h18, 1'b1, 7'd1, 8'h00);    // full
    send_item(MODE_PEEK,  8'h00, 1'b0, 7'd1, 8'd0);
    send_item(MODE_READ,  8'h00, 1'b0, 7'd1, 8'h00);

    // Random phases at several sizes, extremes included.
    for (int p = 0; p < 8; p++) begin
      wait_drained();
      apb_write_size((phase_size[p] == 9'd0) ? 9'($urandom_range(2, 300)) : phase_size[p]);
      run_phase(38);
    end

    wait_drained();
    repeat (16) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl/core
rtl/core/brf_pkg.sv
rtl/core/brf_ring_mem.sv
rtl/core/brf_ctrl.sv
rtl/core/byte_ring_fifo_with_peek.sv
sim/byte_ring_fifo_with_peek_tb.sv
